// File: rtl/core/rvm_pkg.sv
// Shared types, opcodes, tags and error codes of the register VM execute unit.
`timescale 1ns / 1ps
`default_nettype none
package rvm_pkg;

   localparam int unsigned DATA_W = 64;
   localparam int unsigned IP_W   = 16;

   // Value tags
   localparam logic [1:0] TAG_INT  = 2'd0;
   localparam logic [1:0] TAG_BOOL = 2'd1;
   localparam logic [1:0] TAG_NULL = 2'd2;

   // Error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_DIV_ZERO = 2'd1;
   localparam logic [1:0] ERR_MOD_ZERO = 2'd2;
   localparam logic [1:0] ERR_UNSUPP   = 2'd3;

   // Dense opcodes
   localparam logic [5:0] OP_NOP        = 6'd0;
   localparam logic [5:0] OP_HALT       = 6'd1;
   localparam logic [5:0] OP_ADD        = 6'd2;
   localparam logic [5:0] OP_SUB        = 6'd3;
   localparam logic [5:0] OP_MUL        = 6'd4;
   localparam logic [5:0] OP_DIV        = 6'd5;
   localparam logic [5:0] OP_MOD        = 6'd6;
   localparam logic [5:0] OP_NEG        = 6'd7;
   localparam logic [5:0] OP_ABS        = 6'd8;
   localparam logic [5:0] OP_INC        = 6'd9;
   localparam logic [5:0] OP_DEC        = 6'd10;
   localparam logic [5:0] OP_ADDI       = 6'd11;
   localparam logic [5:0] OP_MULI       = 6'd12;
   localparam logic [5:0] OP_EQ         = 6'd13;
   localparam logic [5:0] OP_NE         = 6'd14;
   localparam logic [5:0] OP_LT         = 6'd15;
   localparam logic [5:0] OP_LE         = 6'd16;
   localparam logic [5:0] OP_GT         = 6'd17;
   localparam logic [5:0] OP_GE         = 6'd18;
   localparam logic [5:0] OP_AND        = 6'd19;
   localparam logic [5:0] OP_OR         = 6'd20;
   localparam logic [5:0] OP_XOR        = 6'd21;
   localparam logic [5:0] OP_NOT        = 6'd22;
   localparam logic [5:0] OP_SHL        = 6'd23;
   localparam logic [5:0] OP_SHR        = 6'd24;
   localparam logic [5:0] OP_SAR        = 6'd25;
   localparam logic [5:0] OP_LAND      = 6'd26;
   localparam logic [5:0] OP_OR_B       = 6'd27;
   localparam logic [5:0] OP_LNOT       = 6'd28;
   localparam logic [5:0] OP_MOVE       = 6'd29;
   localparam logic [5:0] OP_LDI        = 6'd30;
   localparam logic [5:0] OP_LDT        = 6'd31;
   localparam logic [5:0] OP_LDF        = 6'd32;
   localparam logic [5:0] OP_LDN        = 6'd33;
   localparam logic [5:0] OP_SWAP       = 6'd34;
   localparam logic [5:0] OP_JUMP       = 6'd35;
   localparam logic [5:0] OP_JMP_TRUE   = 6'd36;
   localparam logic [5:0] OP_JMP_FALSE  = 6'd37;
   localparam logic [5:0] OP_JMP_NULL   = 6'd38;
   localparam logic [5:0] OP_JMP_NNULL  = 6'd39;
   localparam logic [5:0] OP_RET_NULL   = 6'd40;
   localparam logic [5:0] OP_RET_VALUE  = 6'd41;

   // One tagged register value
   typedef struct packed {
      logic [1:0]        tag;
      logic [DATA_W-1:0] pay;
   } value_type;

   // Register file write request; address is the full 8-bit index
   typedef struct packed {
      logic       we;
      logic [7:0] addr;
      value_type  val;
   } rf_wr_type;

   // Register file read request on two ports
   typedef struct packed {
      logic       en;
      logic [7:0] addr_a;
      logic [7:0] addr_b;
      logic       clr_special;
   } rf_rd_type;

   // Truthiness of a tagged value
   function automatic logic truthy(input value_type v);
      logic r;
      if (v.tag == TAG_NULL) begin
         r = 1'b0;
      end else if (v.tag == TAG_INT || v.tag == TAG_BOOL) begin
         r = (v.pay != '0);
      end else begin
         r = 1'b1;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/rvm_if.sv
// Valid/ready channel interfaces for the request and response items.
`timescale 1ns / 1ps
`default_nettype none
interface rvm_req_if;
   logic               valid;
   logic               ready;
   logic [5:0]         op;
   logic [7:0]         dest;
   logic [7:0]         src_a;
   logic [7:0]         src_b;
   logic signed [31:0] immediate;
   logic               start_req;

   modport source (output valid, op, dest, src_a, src_b, immediate, start_req,
                   input ready);
   modport sink   (input valid, op, dest, src_a, src_b, immediate, start_req,
                   output ready);
endinterface

interface rvm_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        next_ip;
   logic               still_running;
   logic [1:0]         error_code;
   logic [1:0]         ret_tag;
   logic signed [63:0] ret_payload;

   modport source (output valid, next_ip, still_running, error_code, ret_tag,
                   ret_payload, input ready);
   modport sink   (input valid, next_ip, still_running, error_code, ret_tag,
                   ret_payload, output ready);
endinterface
`default_nettype wire

// File: rtl/core/rvm_regfile.sv
// Tagged register file: synchronous memory with per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none
module rvm_regfile #(
   parameter int unsigned NUM_REGS = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rvm_pkg::rf_rd_type rd_req,
   input  wire rvm_pkg::rf_wr_type wr_req,
   output rvm_pkg::value_type     rd_a,
   output rvm_pkg::value_type     rd_b
);
   localparam int unsigned IDX_W = $clog2(NUM_REGS);

   rvm_pkg::value_type mem [NUM_REGS];
   logic [NUM_REGS-1:0] valid_ff;

   rvm_pkg::value_type data_a_ff, data_b_ff;
   logic               vld_a_ff, vld_b_ff;
   logic [IDX_W-1:0]   addr_a_ff, addr_b_ff;

   // Memory write and registered reads
   always_ff @(posedge clock) begin
      if (wr_req.we) begin
         mem[wr_req.addr[IDX_W-1:0]] <= wr_req.val;
      end
      if (rd_req.en) begin
         data_a_ff <= mem[rd_req.addr_a[IDX_W-1:0]];
         data_b_ff <= mem[rd_req.addr_b[IDX_W-1:0]];
         vld_a_ff  <= valid_ff[rd_req.addr_a[IDX_W-1:0]];
         vld_b_ff  <= valid_ff[rd_req.addr_b[IDX_W-1:0]];
         addr_a_ff <= rd_req.addr_a[IDX_W-1:0];
         addr_b_ff <= rd_req.addr_b[IDX_W-1:0];
      end
   end

   // Valid bits; a start drops the four special registers back to reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rd_req.clr_special) begin
            valid_ff[3:0] <= 4'b0000;
         end
         if (wr_req.we) begin
            valid_ff[wr_req.addr[IDX_W-1:0]] <= 1'b1;
         end
      end
   end

   // Reset value of an entry by index
   function automatic rvm_pkg::value_type init_val(input logic [IDX_W-1:0] idx);
      rvm_pkg::value_type v;
      if (idx == IDX_W'(0)) begin
         v.tag = rvm_pkg::TAG_INT;
         v.pay = '0;
      end else if (idx == IDX_W'(1)) begin
         v.tag = rvm_pkg::TAG_INT;
         v.pay = rvm_pkg::DATA_W'(1);
      end else begin
         v.tag = rvm_pkg::TAG_NULL;
         v.pay = '0;
      end
      return v;
   endfunction

   assign rd_a = vld_a_ff ? data_a_ff : init_val(addr_a_ff);
   assign rd_b = vld_b_ff ? data_b_ff : init_val(addr_b_ff);
endmodule
`default_nettype wire

// File: rtl/core/rvm_multiplier.sv
// 64 x 64 low-half multiplier built from one 32 x 32 unit in steps LL, LH and HL.
`timescale 1ns / 1ps
`default_nettype none
module rvm_multiplier (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] a,
   input  wire logic [63:0] b,
   output logic             done,
   output logic [63:0]      product
);
   localparam logic [1:0] STEP_LL = 2'd0;
   localparam logic [1:0] STEP_LH = 2'd1;
   localparam logic [1:0] STEP_HL = 2'd2;

   logic        busy_ff, done_ff;
   logic [1:0]  step_ff;
   logic [63:0] a_ff, b_ff, acc_ff;
   logic [31:0] op_x, op_y;
   logic [63:0] pp, term;

   // Select one partial product per step
   always_comb begin
      op_x = (step_ff == STEP_HL) ? a_ff[63:32] : a_ff[31:0];
      op_y = (step_ff == STEP_LH) ? b_ff[63:32] : b_ff[31:0];
      pp   = 64'(op_x) * 64'(op_y);
      term = (step_ff == STEP_LL) ? pp : {pp[31:0], 32'd0};
   end

   // Accumulate partial products
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= STEP_LL;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_LL;
            a_ff    <= a;
            b_ff    <= b;
            acc_ff  <= '0;
         end else if (busy_ff) begin
            acc_ff  <= acc_ff + term;
            step_ff <= step_ff + 2'd1;
            if (step_ff == STEP_HL) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule
`default_nettype wire

// File: rtl/core/rvm_divider.sv
// Unsigned 64-bit restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rvm_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [63:0] divisor,
   output logic             done,
   output logic [63:0]      quotient,
   output logic [63:0]      remainder
);
   logic        busy_ff, done_ff;
   logic [5:0]  cnt_ff;
   logic [63:0] rem_ff, quo_ff, dvs_ff;
   logic [64:0] shifted, diff;

   // Trial subtract of the shifted partial remainder
   always_comb begin
      shifted = {rem_ff, quo_ff[63]};
      diff    = shifted - {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= dividend;
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            // Keep the difference when it did not go negative
            if (!diff[64]) begin
               rem_ff <= diff[63:0];
            end else begin
               rem_ff <= shifted[63:0];
            end
            quo_ff <= {quo_ff[62:0], ~diff[64]};
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

// File: rtl/core/register_vm_execute_unit.sv
// Top level of the register VM execute unit: sequencer, ALU and state.
//
// The feeder sends one instruction item on req_ch, fetched at the last
// next_ip reported on rsp_ch; every item gives exactly one response item.
// The user must write program_length through csr_we/csr_wdata only
// while the unit is idle; the unit itself does not enforce this.
// One item at a time: accept, register file read (two ports), execute,
// then load the response register. Multiply adds three 32x32 partial
// products, then the write-back; divide and modulo add the divider
// steps (one quotient bit per cycle), then the write-back; swap adds a
// second write through the single write port.
// Reset clears the pointer, run flag, return value and the register-file
// valid bits, so registers read their reset values; program_length
// returns to 1. A new item is accepted while a response still waits;
// if the receiver stalls, the next finished result holds in the unit
// until the response register frees.
`timescale 1ns / 1ps
`default_nettype none
module register_vm_execute_unit #(
   parameter int unsigned NUM_REGS = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   rvm_req_if.sink          req_ch,
   rvm_rsp_if.source        rsp_ch,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);
   localparam logic [8:0] REG_LIMIT = 9'(NUM_REGS);

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_SWAP, S_DONE
   } state_type;

   state_type   state_ff, exec_next;
   logic [5:0]  op_ff;
   logic [7:0]  dest_ff, sa_ff, sb_ff;
   logic [31:0] imm_ff;
   logic [15:0] ip_ff, len_ff;
   logic        run_ff;
   logic [1:0]  err_ff;
   rvm_pkg::value_type ret_ff;

   logic        rsp_valid_ff;
   logic [15:0] rsp_ip_ff;
   logic        rsp_run_ff;
   logic [1:0]  rsp_err_ff;
   rvm_pkg::value_type rsp_ret_ff;

   rvm_pkg::rf_rd_type rd_req;
   rvm_pkg::rf_wr_type wr_req;
   rvm_pkg::value_type rd_a, rd_b, opnd_a, opnd_b;

   logic        ok_a, ok_b, ok_d, executes, accept, out_free;
   logic [63:0] imm64, pay_a, pay_b, div_fix;
   logic [5:0]  sh;
   logic [15:0] target, ip_new;
   logic        exec_wr, do_halt, do_ret, do_mul, do_div, do_swap;
   logic [1:0]  err_new;
   rvm_pkg::value_type exec_val, ret_new;
   logic        mul_done, div_done;
   logic [63:0] product, quotient, remainder;

   assign accept   = (state_ff == S_IDLE) && req_ch.valid;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);

   // Register file read: port A takes dest for return-value, port B for swap
   always_comb begin
      rd_req.en          = (state_ff == S_READ);
      rd_req.addr_a      = (op_ff == rvm_pkg::OP_RET_VALUE) ? dest_ff : sa_ff;
      rd_req.addr_b      = (op_ff == rvm_pkg::OP_SWAP) ? dest_ff : sb_ff;
      rd_req.clr_special = accept && req_ch.start_req;
   end

   // Range checks; out-of-range reads as null zero
   always_comb begin
      ok_a = {1'b0, rd_req.addr_a} < REG_LIMIT;
      ok_b = {1'b0, rd_req.addr_b} < REG_LIMIT;
      ok_d = {1'b0, dest_ff} < REG_LIMIT;
      opnd_a.tag = ok_a ? rd_a.tag : rvm_pkg::TAG_NULL;
      opnd_a.pay = ok_a ? rd_a.pay : '0;
      opnd_b.tag = ok_b ? rd_b.tag : rvm_pkg::TAG_NULL;
      opnd_b.pay = ok_b ? rd_b.pay : '0;
      pay_a = opnd_a.pay;
      pay_b = opnd_b.pay;
      sh    = pay_b[5:0];
      imm64 = {{32{imm_ff[31]}}, imm_ff};
      target = (imm_ff[31:16] != 16'd0) ? 16'hFFFF : imm_ff[15:0];
      executes = run_ff && (ip_ff < len_ff);
   end

   // Decode and combinational ALU
   always_comb begin
      exec_wr  = 1'b0;
      exec_val.tag = rvm_pkg::TAG_INT;
      exec_val.pay = '0;
      do_halt  = 1'b0;
      do_ret   = 1'b0;
      ret_new  = opnd_a;
      do_mul   = 1'b0;
      do_div   = 1'b0;
      do_swap  = 1'b0;
      err_new  = rvm_pkg::ERR_NONE;
      ip_new   = ip_ff + 16'd1;
      unique case (op_ff) inside
         rvm_pkg::OP_NOP: ;
         rvm_pkg::OP_HALT: do_halt = 1'b1;
         rvm_pkg::OP_ADD: begin exec_wr = 1'b1; exec_val.pay = pay_a + pay_b; end
         rvm_pkg::OP_SUB: begin exec_wr = 1'b1; exec_val.pay = pay_a - pay_b; end
         rvm_pkg::OP_MUL, rvm_pkg::OP_MULI: do_mul = 1'b1;
         rvm_pkg::OP_DIV, rvm_pkg::OP_MOD: begin
            if (pay_b == '0) begin
               err_new = (op_ff == rvm_pkg::OP_DIV) ? rvm_pkg::ERR_DIV_ZERO
                                                    : rvm_pkg::ERR_MOD_ZERO;
            end else begin
               do_div = 1'b1;
            end
         end
         rvm_pkg::OP_NEG: begin exec_wr = 1'b1; exec_val.pay = '0 - pay_a; end
         rvm_pkg::OP_ABS: begin
            exec_wr = 1'b1;
            exec_val.pay = pay_a[63] ? ('0 - pay_a) : pay_a;
         end
         rvm_pkg::OP_INC: begin exec_wr = 1'b1; exec_val.pay = pay_a + 64'd1; end
         rvm_pkg::OP_DEC: begin exec_wr = 1'b1; exec_val.pay = pay_a - 64'd1; end
         rvm_pkg::OP_ADDI: begin exec_wr = 1'b1; exec_val.pay = pay_a + imm64; end
         rvm_pkg::OP_EQ: begin
            exec_wr = 1'b1; exec_val.tag = rvm_pkg::TAG_BOOL;
            exec_val.pay = 64'(pay_a == pay_b);
         end
         rvm_pkg::OP_NE: begin
            exec_wr = 1'b1; exec_val.tag = rvm_pkg::TAG_BOOL;
            exec_val.pay = 64'(pay_a != pay_b);
         end
         rvm_pkg::OP_LT: begin
            exec_wr = 1'b1; exec_val.tag = rvm_pkg::TAG_BOOL;
            exec_val.pay = 64'($signed(pay_a) < $signed(pay_b));
         end
         rvm_pkg::OP_LE: begin
            exec_wr = 1'b1; exec_val.tag = rvm_pkg::TAG_BOOL;
            exec_val.pay = 64'($signed(pay_a) <= $signed(pay_b));
         end
         rvm_pkg::OP_GT: begin
            exec_wr = 1'b1; exec_val.tag = rvm_pkg::TAG_BOOL;
            exec_val.pay = 64'($signed(pay_a) > $signed(pay_b));
         end
         rvm_pkg::OP_GE: begin
            exec_wr = 1'b1; exec_val.tag = rvm_pkg::TAG_BOOL;
            exec_val.pay = 64'($signed(pay_a) >= $signed(pay_b));
         end
         rvm_pkg::OP_AND: begin exec_wr = 1'b1; exec_val.pay = pay_a & pay_b; end
         rvm_pkg::OP_OR:  begin exec_wr = 1'b1; exec_val.pay = pay_a | pay_b; end
         rvm_pkg::OP_XOR: begin exec_wr = 1'b1; exec_val.pay = pay_a ^ pay_b; end
         rvm_pkg::OP_NOT: begin exec_wr = 1'b1; exec_val.pay = ~pay_a; end
         rvm_pkg::OP_SHL: begin exec_wr = 1'b1; exec_val.pay = pay_a << sh; end
         rvm_pkg::OP_SHR: begin exec_wr = 1'b1; exec_val.pay = pay_a >> sh; end
         rvm_pkg::OP_SAR: begin
            exec_wr = 1'b1;
            exec_val.pay = 64'($signed(pay_a) >>> sh);
         end
         rvm_pkg::OP_LAND: begin
            exec_wr = 1'b1; exec_val.tag = rvm_pkg::TAG_BOOL;
            exec_val.pay = 64'(rvm_pkg::truthy(opnd_a) && rvm_pkg::truthy(opnd_b));
         end
         rvm_pkg::OP_OR_B: begin
            exec_wr = 1'b1; exec_val.tag = rvm_pkg::TAG_BOOL;
            exec_val.pay = 64'(rvm_pkg::truthy(opnd_a) || rvm_pkg::truthy(opnd_b));
         end
         rvm_pkg::OP_LNOT: begin
            exec_wr = 1'b1; exec_val.tag = rvm_pkg::TAG_BOOL;
            exec_val.pay = 64'(!rvm_pkg::truthy(opnd_a));
         end
         rvm_pkg::OP_MOVE: begin exec_wr = 1'b1; exec_val = opnd_a; end
         rvm_pkg::OP_LDI: begin exec_wr = 1'b1; exec_val.pay = imm64; end
         rvm_pkg::OP_LDT: begin
            exec_wr = 1'b1; exec_val.tag = rvm_pkg::TAG_BOOL; exec_val.pay = 64'd1;
         end
         rvm_pkg::OP_LDF: begin
            exec_wr = 1'b1; exec_val.tag = rvm_pkg::TAG_BOOL;
         end
         rvm_pkg::OP_LDN: begin
            exec_wr = 1'b1; exec_val.tag = rvm_pkg::TAG_NULL;
         end
         rvm_pkg::OP_SWAP: begin
            // First write dest <- src_a, second write src_a <- old dest
            if (ok_a && ok_b) begin
               exec_wr  = 1'b1;
               exec_val = opnd_a;
               do_swap  = 1'b1;
            end
         end
         rvm_pkg::OP_JUMP: ip_new = target;
         rvm_pkg::OP_JMP_TRUE: if (rvm_pkg::truthy(opnd_a)) ip_new = target;
         rvm_pkg::OP_JMP_FALSE: if (!rvm_pkg::truthy(opnd_a)) ip_new = target;
         rvm_pkg::OP_JMP_NULL: if (opnd_a.tag == rvm_pkg::TAG_NULL) ip_new = target;
         rvm_pkg::OP_JMP_NNULL: if (opnd_a.tag != rvm_pkg::TAG_NULL) ip_new = target;
         rvm_pkg::OP_RET_NULL: begin
            do_ret = 1'b1;
            ret_new.tag = rvm_pkg::TAG_NULL;
            ret_new.pay = '0;
         end
         rvm_pkg::OP_RET_VALUE: do_ret = 1'b1;
         default: err_new = rvm_pkg::ERR_UNSUPP;
      endcase

      if (do_mul) begin
         exec_next = S_MUL;
      end else if (do_div) begin
         exec_next = S_DIV;
      end else if (do_swap) begin
         exec_next = S_SWAP;
      end else begin
         exec_next = S_DONE;
      end
      if (!executes) begin
         exec_next = S_DONE;
      end
   end

   // Signed fix-up of the divider result
   always_comb begin
      if (op_ff == rvm_pkg::OP_DIV) begin
         div_fix = (pay_a[63] != pay_b[63]) ? ('0 - quotient) : quotient;
      end else begin
         div_fix = pay_a[63] ? ('0 - remainder) : remainder;
      end
   end

   // Single write port: ALU, multiplier, divider or second half of swap
   always_comb begin
      wr_req.we   = 1'b0;
      wr_req.addr = dest_ff;
      wr_req.val  = exec_val;
      case (state_ff)
         S_EXEC: wr_req.we = executes && exec_wr && ok_d;
         S_MUL: begin
            wr_req.we      = mul_done && ok_d;
            wr_req.val.tag = rvm_pkg::TAG_INT;
            wr_req.val.pay = product;
         end
         S_DIV: begin
            wr_req.we      = div_done && ok_d;
            wr_req.val.tag = rvm_pkg::TAG_INT;
            wr_req.val.pay = div_fix;
         end
         S_SWAP: begin
            wr_req.we   = 1'b1;
            wr_req.addr = sa_ff;
            wr_req.val  = opnd_b;
         end
         default: ;
      endcase
   end

   rvm_regfile #(.NUM_REGS(NUM_REGS)) u_regfile (
      .clock  (clock),
      .reset  (reset),
      .rd_req (rd_req),
      .wr_req (wr_req),
      .rd_a   (rd_a),
      .rd_b   (rd_b)
   );

   rvm_multiplier u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   ((state_ff == S_EXEC) && executes && do_mul),
      .a       (pay_a),
      .b       ((op_ff == rvm_pkg::OP_MULI) ? imm64 : pay_b),
      .done    (mul_done),
      .product (product)
   );

   rvm_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     ((state_ff == S_EXEC) && executes && do_div),
      .dividend  (pay_a[63] ? ('0 - pay_a) : pay_a),
      .divisor   (pay_b[63] ? ('0 - pay_b) : pay_b),
      .done      (div_done),
      .quotient  (quotient),
      .remainder (remainder)
   );

   // Sequencer, architectural state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ip_ff        <= '0;
         run_ff       <= 1'b0;
         err_ff       <= rvm_pkg::ERR_NONE;
         ret_ff.tag   <= rvm_pkg::TAG_NULL;
         ret_ff.pay   <= '0;
         len_ff       <= 16'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            len_ff <= csr_wdata;
         end
         // Load a finished response when the register frees, else drop a taken one
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  op_ff    <= req_ch.op;
                  dest_ff  <= req_ch.dest;
                  sa_ff    <= req_ch.src_a;
                  sb_ff    <= req_ch.src_b;
                  imm_ff   <= req_ch.immediate;
                  err_ff   <= rvm_pkg::ERR_NONE;
                  if (req_ch.start_req) begin
                     ip_ff  <= '0;
                     run_ff <= 1'b1;
                  end
                  state_ff <= S_READ;
               end
            end
            S_READ: state_ff <= S_EXEC;
            S_EXEC: begin
               if (executes) begin
                  ip_ff  <= ip_new;
                  err_ff <= err_new;
                  if (do_halt || do_ret || err_new != rvm_pkg::ERR_NONE) begin
                     run_ff <= 1'b0;
                  end
                  if (do_ret) begin
                     ret_ff <= ret_new;
                  end
               end
               state_ff <= exec_next;
            end
            S_MUL: if (mul_done) state_ff <= S_DONE;
            S_DIV: if (div_done) state_ff <= S_DONE;
            S_SWAP: state_ff <= S_DONE;
            S_DONE: begin
               // Hold until the response register frees, then end-of-program check
               if (out_free) begin
                  rsp_ip_ff    <= ip_ff;
                  rsp_run_ff   <= run_ff && (ip_ff < len_ff);
                  rsp_err_ff   <= err_ff;
                  rsp_ret_ff   <= ret_ff;
                  run_ff       <= run_ff && (ip_ff < len_ff);
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.next_ip       = rsp_ip_ff;
   assign rsp_ch.still_running = rsp_run_ff;
   assign rsp_ch.error_code    = rsp_err_ff;
   assign rsp_ch.ret_tag       = rsp_ret_ff.tag;
   assign rsp_ch.ret_payload   = rsp_ret_ff.pay;
endmodule
`default_nettype wire
